/* hw/rtl/frag_pkg.sv */
// ----------------------------------------------------------------------------
// frag_pkg
// Shared constants, codes and control types of the fragment reassembler.
// ----------------------------------------------------------------------------
`default_nettype none

package frag_pkg;

    localparam int MAX_PACKET_BYTES_DEF  = 256;
    localparam int MAX_CHUNK_PAYLOAD_DEF = 64;
    localparam int HEADER_BYTES          = 5;

    localparam int LEN_W      = 9;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [LEN_W-1:0] LEN_SAT        = 9'd511;
    localparam logic [7:0]       MARKER_RST     = 8'hFF;
    localparam logic [15:0]      TIMEOUT_RST    = 16'd1000;
    localparam logic [LEN_W-1:0] MIN_DIRECT_RST = 9'd1;

    // command codes of a request transfer
    localparam logic [1:0] OP_BYTE = 2'd0;
    localparam logic [1:0] OP_TICK = 2'd1;
    localparam logic [1:0] OP_READ = 2'd2;
    localparam logic [1:0] OP_NONE = 2'd3;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_MARKER     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_DIRECT = 2'd2;

    // result status codes
    localparam logic [2:0] ST_CHUNK_OK   = 3'd0;
    localparam logic [2:0] ST_COMPLETE   = 3'd1;
    localparam logic [2:0] ST_DIRECT_OK  = 3'd2;
    localparam logic [2:0] ST_BAD_INDEX  = 3'd3;
    localparam logic [2:0] ST_BAD_SIZE   = 3'd4;
    localparam logic [2:0] ST_OUT_OF_SEQ = 3'd5;
    localparam logic [2:0] ST_TIMED_OUT  = 3'd6;
    localparam logic [2:0] ST_READ_DATA  = 3'd7;

    typedef enum logic [2:0] {
        S_IDLE,
        S_BYTE,
        S_EVAL,
        S_CP_RD,
        S_CP_WR,
        S_FINISH,
        S_TICK,
        S_READ
    } frag_state_t;

    typedef struct packed {
        logic latch_req;
        logic store_byte;
        logic eval_commit;
        logic copy_rd;
        logic copy_wr;
        logic finish_commit;
        logic tick_commit;
        logic read_emit;
    } frag_cmd_t;

    typedef struct packed {
        logic frame_end;
        logic out_free;
        logic eval_emits;
        logic copy_last;
        logic assembling;
        logic tick_fire;
    } frag_sts_t;

endpackage

`default_nettype wire

/* hw/rtl/frag_if.sv */
// ----------------------------------------------------------------------------
// frag_if
// Valid/ready channels of the fragment reassembler: request, response and
// configuration write.
// ----------------------------------------------------------------------------
`default_nettype none

interface frag_req_if;
    logic       valid;
    logic       ready;
    logic [1:0] cmd;
    logic [7:0] data_byte;
    logic       frame_end;
    logic [7:0] read_index;

    modport source (output valid, cmd, data_byte, frame_end, read_index, input ready);
    modport sink   (input valid, cmd, data_byte, frame_end, read_index, output ready);
endinterface

interface frag_rsp_if;
    logic                         valid;
    logic                         ready;
    logic [2:0]                   status;
    logic [frag_pkg::LEN_W-1:0]   total_length;
    logic [7:0]                   read_byte;

    modport source (output valid, status, total_length, read_byte, input ready);
    modport sink   (input valid, status, total_length, read_byte, output ready);
endinterface

interface frag_cfg_if;
    logic                            valid;
    logic                            ready;
    logic [frag_pkg::CFG_IDX_W-1:0]  index;
    logic [frag_pkg::CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

/* hw/rtl/frag_ram.sv */
// ----------------------------------------------------------------------------
// frag_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
`default_nettype none

module frag_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic             re,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

/* hw/rtl/frag_ctrl.sv */
// ----------------------------------------------------------------------------
// frag_ctrl
// Controller: sequences byte store, frame evaluation, payload copy, tick and
// read handling, and holds result-producing steps until the output is free.
// ----------------------------------------------------------------------------
`default_nettype none

module frag_ctrl (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                req_valid,
    input  wire logic [1:0]          req_cmd,
    output logic                     req_ready,
    input  wire frag_pkg::frag_sts_t sts,
    output frag_pkg::frag_cmd_t      cmd
);

    frag_pkg::frag_state_t state_reg;
    frag_pkg::frag_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= frag_pkg::S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            frag_pkg::S_IDLE:
            begin
                if (req_valid)
                begin
                    case (req_cmd)
                        frag_pkg::OP_BYTE: state_next = frag_pkg::S_BYTE;
                        frag_pkg::OP_TICK: state_next = frag_pkg::S_TICK;
                        frag_pkg::OP_READ: state_next = frag_pkg::S_READ;
                        default:           state_next = frag_pkg::S_IDLE;
                    endcase
                end
            end
            frag_pkg::S_BYTE:
            begin
                state_next = sts.frame_end ? frag_pkg::S_EVAL : frag_pkg::S_IDLE;
            end
            frag_pkg::S_EVAL:
            begin
                if (!sts.eval_emits)
                begin
                    state_next = frag_pkg::S_CP_RD;
                end
                else if (sts.out_free)
                begin
                    state_next = frag_pkg::S_IDLE;
                end
            end
            frag_pkg::S_CP_RD:
            begin
                state_next = frag_pkg::S_CP_WR;
            end
            frag_pkg::S_CP_WR:
            begin
                state_next = sts.copy_last ? frag_pkg::S_FINISH : frag_pkg::S_CP_RD;
            end
            frag_pkg::S_FINISH:
            begin
                if (sts.out_free)
                begin
                    state_next = frag_pkg::S_IDLE;
                end
            end
            frag_pkg::S_TICK:
            begin
                if (!sts.assembling || !sts.tick_fire || sts.out_free)
                begin
                    state_next = frag_pkg::S_IDLE;
                end
            end
            frag_pkg::S_READ:
            begin
                if (sts.out_free)
                begin
                    state_next = frag_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = frag_pkg::S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        req_ready         = (state_reg == frag_pkg::S_IDLE);
        cmd               = '0;
        cmd.latch_req     = (state_reg == frag_pkg::S_IDLE) && req_valid;
        cmd.store_byte    = (state_reg == frag_pkg::S_BYTE);
        cmd.eval_commit   = (state_reg == frag_pkg::S_EVAL)
                            && (!sts.eval_emits || sts.out_free);
        cmd.copy_rd       = (state_reg == frag_pkg::S_CP_RD);
        cmd.copy_wr       = (state_reg == frag_pkg::S_CP_WR);
        cmd.finish_commit = (state_reg == frag_pkg::S_FINISH) && sts.out_free;
        cmd.tick_commit   = (state_reg == frag_pkg::S_TICK) && sts.assembling
                            && (!sts.tick_fire || sts.out_free);
        cmd.read_emit     = (state_reg == frag_pkg::S_READ) && sts.out_free;
    end

endmodule

`default_nettype wire

/* hw/rtl/frag_dp.sv */
// ----------------------------------------------------------------------------
// frag_dp
// Datapath: configuration registers, frame and assembly state, header checks,
// staging and assembly buffers, and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module frag_dp #(
    parameter int MAX_PACKET_BYTES  = frag_pkg::MAX_PACKET_BYTES_DEF,
    parameter int MAX_CHUNK_PAYLOAD = frag_pkg::MAX_CHUNK_PAYLOAD_DEF
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire frag_pkg::frag_cmd_t             cmd,
    output frag_pkg::frag_sts_t                  sts,
    input  wire logic [1:0]                      req_cmd,
    input  wire logic [7:0]                      req_data_byte,
    input  wire logic                            req_frame_end,
    input  wire logic [7:0]                      req_read_index,
    input  wire logic                            cfg_valid,
    input  wire logic [frag_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [frag_pkg::CFG_DATA_W-1:0] cfg_data,
    output logic                                 rsp_valid,
    input  wire logic                            rsp_ready,
    output logic [2:0]                           rsp_status,
    output logic [frag_pkg::LEN_W-1:0]           rsp_total_length,
    output logic [7:0]                           rsp_read_byte
);

    localparam int HB  = frag_pkg::HEADER_BYTES;
    localparam int LW  = frag_pkg::LEN_W;
    localparam int AW  = (MAX_PACKET_BYTES > 1) ? $clog2(MAX_PACKET_BYTES) : 1;
    localparam int SAW = (MAX_CHUNK_PAYLOAD > 1) ? $clog2(MAX_CHUNK_PAYLOAD) : 1;

    localparam logic [LW:0]   MAXP_W = (LW+1)'(MAX_PACKET_BYTES);
    localparam logic [7:0]    MCP_8  = 8'(MAX_CHUNK_PAYLOAD);
    localparam logic [LW-1:0] MCP_9  = LW'(MAX_CHUNK_PAYLOAD);
    localparam logic [LW-1:0] HB_9   = LW'(HB);
    localparam logic [LW:0]   HB_10  = (LW+1)'(HB);

    // configuration
    logic [7:0]    marker_reg,  marker_next;
    logic [15:0]   timeout_reg, timeout_next;
    logic [LW-1:0] min_reg,     min_next;

    // latched request
    logic       last_reg;
    logic [7:0] byte_reg;
    logic [7:0] ridx_reg;

    // frame and assembly state
    logic [LW-1:0] frame_pos_reg, frame_pos_next;
    logic [LW-1:0] len_reg,       len_next;
    logic [7:0]    hdr_reg [HB];
    logic [7:0]    hdr_next [HB];
    logic          asm_reg,  asm_next;
    logic [7:0]    msg_reg,  msg_next;
    logic [7:0]    ecnt_reg, ecnt_next;
    logic [7:0]    nei_reg,  nei_next;
    logic [LW-1:0] alen_reg, alen_next;
    logic [15:0]   idle_reg, idle_next;
    logic [7:0]    cp_reg,   cp_next;

    // result register
    logic          rsp_valid_reg, rsp_valid_next;
    logic [2:0]    status_reg,    status_next;
    logic [LW-1:0] total_reg,     total_next;
    logic [7:0]    rbyte_reg,     rbyte_next;

    // buffers
    logic           stg_we;
    logic [LW-1:0]  stg_off;
    logic [7:0]     stg_rdata;
    logic [LW:0]    asm_waddr_full;
    logic           asm_re;
    logic [7:0]     asm_rdata;

    // evaluation
    logic [LW-1:0] pos_inc;
    logic [7:0]    h_id, h_idx, h_cnt, h_plen;
    logic          is_frag, bad_idx, bad_size, start, seq_fail, ovf, frag_ok;
    logic          direct_bad;
    logic [LW-1:0] base_len;
    logic [2:0]    eval_status;
    logic [LW-1:0] alen_sum;
    logic [7:0]    nei_inc;
    logic          complete;
    logic [15:0]   idle_inc;
    logic          tick_fire;
    logic          out_free;

    assign h_id   = hdr_reg[1];
    assign h_idx  = hdr_reg[2];
    assign h_cnt  = hdr_reg[3];
    assign h_plen = hdr_reg[4];

    assign pos_inc = (frame_pos_reg == frag_pkg::LEN_SAT) ? frag_pkg::LEN_SAT
                                                           : frame_pos_reg + 9'd1;
    assign stg_off = frame_pos_reg - HB_9;
    assign stg_we  = cmd.store_byte && (frame_pos_reg >= HB_9) && (stg_off < MCP_9);

    assign is_frag    = (len_reg >= HB_9) && (hdr_reg[0] == marker_reg);
    assign bad_idx    = (h_cnt == 8'd0) || (h_idx >= h_cnt);
    assign bad_size   = ({1'b0, len_reg} != HB_10 + {2'b00, h_plen})
                        || (h_plen == 8'd0) || (h_plen > MCP_8);
    assign start      = (h_idx == 8'd0);
    assign seq_fail   = !start && (!asm_reg || (msg_reg != h_id)
                        || (ecnt_reg != h_cnt) || (nei_reg != h_idx));
    assign base_len   = start ? '0 : alen_reg;
    assign ovf        = ({1'b0, base_len} + {2'b00, h_plen}) > MAXP_W;
    assign frag_ok    = is_frag && !bad_idx && !bad_size && !seq_fail && !ovf;
    assign direct_bad = (len_reg < min_reg) || ({1'b0, len_reg} > MAXP_W);

    always_comb
    begin
        if (!is_frag)
        begin
            eval_status = direct_bad ? frag_pkg::ST_BAD_SIZE : frag_pkg::ST_DIRECT_OK;
        end
        else if (bad_idx)
        begin
            eval_status = frag_pkg::ST_BAD_INDEX;
        end
        else if (bad_size)
        begin
            eval_status = frag_pkg::ST_BAD_SIZE;
        end
        else if (seq_fail)
        begin
            eval_status = frag_pkg::ST_OUT_OF_SEQ;
        end
        else
        begin
            eval_status = frag_pkg::ST_BAD_SIZE;
        end
    end

    assign alen_sum  = alen_reg + {1'b0, h_plen};
    assign nei_inc   = nei_reg + 8'd1;
    assign complete  = !(nei_inc < ecnt_reg);
    assign idle_inc  = (idle_reg == 16'hFFFF) ? idle_reg : idle_reg + 16'd1;
    assign tick_fire = (idle_inc >= timeout_reg);
    assign out_free  = !rsp_valid_reg || rsp_ready;

    assign asm_waddr_full = {1'b0, alen_reg} + {2'b00, cp_reg};
    assign asm_re         = cmd.latch_req && (req_cmd == frag_pkg::OP_READ);

    always_comb
    begin
        sts            = '0;
        sts.frame_end  = last_reg;
        sts.out_free   = out_free;
        sts.eval_emits = !frag_ok;
        sts.copy_last  = ({1'b0, cp_reg} + 9'd1) == {1'b0, h_plen};
        sts.assembling = asm_reg;
        sts.tick_fire  = tick_fire;
    end

    // configuration writes
    always_comb
    begin
        marker_next  = marker_reg;
        timeout_next = timeout_reg;
        min_next     = min_reg;
        if (cfg_valid)
        begin
            case (cfg_index)
                frag_pkg::REG_MARKER:     marker_next  = cfg_data[7:0];
                frag_pkg::REG_TIMEOUT:    timeout_next = cfg_data;
                frag_pkg::REG_MIN_DIRECT: min_next     = cfg_data[LW-1:0];
                default:                  ;
            endcase
        end
    end

    // frame and assembly state
    always_comb
    begin
        frame_pos_next = frame_pos_reg;
        len_next       = len_reg;
        hdr_next       = hdr_reg;
        asm_next       = asm_reg;
        msg_next       = msg_reg;
        ecnt_next      = ecnt_reg;
        nei_next       = nei_reg;
        alen_next      = alen_reg;
        idle_next      = idle_reg;
        cp_next        = cp_reg;

        if (cmd.store_byte)
        begin
            if (frame_pos_reg < HB_9)
            begin
                hdr_next[frame_pos_reg[2:0]] = byte_reg;
            end
            len_next       = pos_inc;
            frame_pos_next = last_reg ? '0 : pos_inc;
        end

        if (cmd.eval_commit)
        begin
            cp_next = '0;
            if (frag_ok && start)
            begin
                asm_next  = 1'b1;
                msg_next  = h_id;
                ecnt_next = h_cnt;
                nei_next  = '0;
                alen_next = '0;
                idle_next = '0;
            end
            else if (is_frag && !bad_idx && !bad_size && !seq_fail && ovf)
            begin
                asm_next  = 1'b0;
                msg_next  = '0;
                ecnt_next = '0;
                nei_next  = '0;
                alen_next = '0;
                idle_next = '0;
            end
        end

        if (cmd.copy_wr)
        begin
            cp_next = cp_reg + 8'd1;
        end

        if (cmd.finish_commit)
        begin
            if (complete)
            begin
                asm_next  = 1'b0;
                msg_next  = '0;
                ecnt_next = '0;
                nei_next  = '0;
                alen_next = '0;
                idle_next = '0;
            end
            else
            begin
                alen_next = alen_sum;
                nei_next  = nei_inc;
                idle_next = '0;
            end
        end

        if (cmd.tick_commit)
        begin
            if (tick_fire)
            begin
                asm_next  = 1'b0;
                msg_next  = '0;
                ecnt_next = '0;
                nei_next  = '0;
                alen_next = '0;
                idle_next = '0;
            end
            else
            begin
                idle_next = idle_inc;
            end
        end
    end

    // result register
    always_comb
    begin
        rsp_valid_next = rsp_valid_reg && !rsp_ready;
        status_next    = status_reg;
        total_next     = total_reg;
        rbyte_next     = rbyte_reg;
        if (cmd.eval_commit && !frag_ok)
        begin
            rsp_valid_next = 1'b1;
            status_next    = eval_status;
            total_next     = is_frag ? '0 : len_reg;
            rbyte_next     = '0;
        end
        else if (cmd.finish_commit)
        begin
            rsp_valid_next = 1'b1;
            status_next    = complete ? frag_pkg::ST_COMPLETE : frag_pkg::ST_CHUNK_OK;
            total_next     = complete ? alen_sum : '0;
            rbyte_next     = '0;
        end
        else if (cmd.tick_commit && tick_fire)
        begin
            rsp_valid_next = 1'b1;
            status_next    = frag_pkg::ST_TIMED_OUT;
            total_next     = '0;
            rbyte_next     = '0;
        end
        else if (cmd.read_emit)
        begin
            rsp_valid_next = 1'b1;
            status_next    = frag_pkg::ST_READ_DATA;
            total_next     = '0;
            rbyte_next     = ({2'b00, ridx_reg} < MAXP_W) ? asm_rdata : 8'd0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            marker_reg    <= frag_pkg::MARKER_RST;
            timeout_reg   <= frag_pkg::TIMEOUT_RST;
            min_reg       <= frag_pkg::MIN_DIRECT_RST;
            frame_pos_reg <= '0;
            len_reg       <= '0;
            for (int i = 0; i < HB; i++)
            begin
                hdr_reg[i] <= '0;
            end
            asm_reg       <= 1'b0;
            msg_reg       <= '0;
            ecnt_reg      <= '0;
            nei_reg       <= '0;
            alen_reg      <= '0;
            idle_reg      <= '0;
            cp_reg        <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            marker_reg    <= marker_next;
            timeout_reg   <= timeout_next;
            min_reg       <= min_next;
            frame_pos_reg <= frame_pos_next;
            len_reg       <= len_next;
            hdr_reg       <= hdr_next;
            asm_reg       <= asm_next;
            msg_reg       <= msg_next;
            ecnt_reg      <= ecnt_next;
            nei_reg       <= nei_next;
            alen_reg      <= alen_next;
            idle_reg      <= idle_next;
            cp_reg        <= cp_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.latch_req)
        begin
            last_reg <= req_frame_end;
            byte_reg <= req_data_byte;
            ridx_reg <= req_read_index;
        end
        status_reg <= status_next;
        total_reg  <= total_next;
        rbyte_reg  <= rbyte_next;
    end

    frag_ram #(
        .WIDTH (8),
        .DEPTH (MAX_CHUNK_PAYLOAD)
    ) u_stage_ram (
        .clk   (clk),
        .we    (stg_we),
        .waddr (stg_off[SAW-1:0]),
        .wdata (byte_reg),
        .re    (cmd.copy_rd),
        .raddr (cp_reg[SAW-1:0]),
        .rdata (stg_rdata)
    );

    frag_ram #(
        .WIDTH (8),
        .DEPTH (MAX_PACKET_BYTES)
    ) u_asm_ram (
        .clk   (clk),
        .we    (cmd.copy_wr),
        .waddr (asm_waddr_full[AW-1:0]),
        .wdata (stg_rdata),
        .re    (asm_re),
        .raddr (req_read_index[AW-1:0]),
        .rdata (asm_rdata)
    );

    assign rsp_valid        = rsp_valid_reg;
    assign rsp_status       = status_reg;
    assign rsp_total_length = total_reg;
    assign rsp_read_byte    = rbyte_reg;

endmodule

`default_nettype wire

/* hw/rtl/fragment_reassembler.sv */
// ----------------------------------------------------------------------------
// fragment_reassembler
// Reassembles fragmented messages from a byte stream, checks direct frames,
// times out stale assemblies and serves reads of the assembly buffer.
//
//   channel  role   handshake     payload
//   req      sink   valid/ready   cmd, data_byte, frame_end, read_index
//   rsp      source valid/ready   status, total_length, read_byte
//   cfg      sink   valid/ready   index, data (ready tied high)
//
// Frame byte without end: stored in S_BYTE. Unused command: back to idle.
// Tick, read: handled in S_TICK, S_READ. Frame end: evaluated in S_EVAL, where
// a direct frame or a rejected fragment gets its result. An accepted fragment is
// copied byte by byte from the staging RAM into the assembly RAM, then finished.
// Steps that produce a result hold until the output register is free.
// Asynchronous reset clears control state; the buffers are not cleared.
// ----------------------------------------------------------------------------
`default_nettype none

module fragment_reassembler #(
    parameter int MAX_PACKET_BYTES  = frag_pkg::MAX_PACKET_BYTES_DEF,
    parameter int MAX_CHUNK_PAYLOAD = frag_pkg::MAX_CHUNK_PAYLOAD_DEF
) (
    input  wire logic  clk,
    input  wire logic  rst_n,
    frag_req_if.sink   req,
    frag_rsp_if.source rsp,
    frag_cfg_if.sink   cfg
);

    frag_pkg::frag_cmd_t ctl_cmd;
    frag_pkg::frag_sts_t dp_sts;

    assign cfg.ready = 1'b1;

    frag_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_cmd   (req.cmd),
        .req_ready (req.ready),
        .sts       (dp_sts),
        .cmd       (ctl_cmd)
    );

    frag_dp #(
        .MAX_PACKET_BYTES  (MAX_PACKET_BYTES),
        .MAX_CHUNK_PAYLOAD (MAX_CHUNK_PAYLOAD)
    ) u_dp (
        .clk              (clk),
        .rst_n            (rst_n),
        .cmd              (ctl_cmd),
        .sts              (dp_sts),
        .req_cmd          (req.cmd),
        .req_data_byte    (req.data_byte),
        .req_frame_end    (req.frame_end),
        .req_read_index   (req.read_index),
        .cfg_valid        (cfg.valid),
        .cfg_index        (cfg.index),
        .cfg_data         (cfg.data),
        .rsp_valid        (rsp.valid),
        .rsp_ready        (rsp.ready),
        .rsp_status       (rsp.status),
        .rsp_total_length (rsp.total_length),
        .rsp_read_byte    (rsp.read_byte)
    );

`ifndef SYNTHESIS
    assert property (@(posedge clk) disable iff (!rst_n)
        (req.valid && req.ready && req.cmd == frag_pkg::OP_NONE) |=> req.ready)
        else $error("unused command did not return to idle");

    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp.valid) |-> $past(ctl_cmd.eval_commit || ctl_cmd.finish_commit
                                   || ctl_cmd.tick_commit || ctl_cmd.read_emit))
        else $error("result appeared without a commit");

    assert property (@(posedge clk) disable iff (!rst_n)
        ctl_cmd.finish_commit |-> dp_sts.assembling)
        else $error("chunk finished with no active assembly");
`endif

endmodule

`default_nettype wire
